@@ rtl/core/token_mutual_exclusion_node_core_assert.svh @@
// assertion macros shared by the node core
`ifndef TOKEN_MUTUAL_EXCLUSION_NODE_CORE_ASSERT_SVH
`define TOKEN_MUTUAL_EXCLUSION_NODE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define TMXN_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen at a clock edge out of reset
`define TMXN_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TMXN_ASSERT(name, clk, rst_n, prop, msg)
`define TMXN_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/core/tmxn_pkg.sv @@
package tmxn_pkg;

  // default sizing
  localparam int NODES_DEFAULT      = 5;
  localparam int COUNT_BITS_DEFAULT = 16;

  // item field widths
  localparam int REQ_TYPE_W  = 2;
  localparam int NODE_W      = 3;
  localparam int REQN_W      = 16;
  localparam int INDEX_W     = 3;
  localparam int VALUE_W     = 16;
  localparam int KIND_W      = 2;
  localparam int DEST_W      = 3;
  localparam int SEQ_W       = 16;

  // configuration port
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 1;
  localparam logic [REG_IDX_W-1:0] REG_NODE_NUMBER = 1'b0;

  // input item kinds
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ENTRY  = 2'd0,
    REQ_REMOTE = 2'd1,
    REQ_TOKEN  = 2'd2,
    REQ_EXIT   = 2'd3
  } req_type_e;

  // result item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_TOKEN   = 2'd1,
    KIND_GRANT   = 2'd2
  } out_kind_e;

  // operand selection of the shared compare unit
  typedef enum logic [1:0] {
    CMP_REQ_UPD = 2'd0,
    CMP_PENDING = 2'd1,
    CMP_SAT     = 2'd2
  } cmp_op_e;

  // write strobes into the count tables
  typedef struct packed {
    logic hr_we;
    logic sc_we;
  } tbl_we_t;

  // one result item
  typedef struct packed {
    out_kind_e            out_kind;
    logic [DEST_W-1:0]    dest_node;
    logic [SEQ_W-1:0]     seq_out;
    logic [INDEX_W-1:0]   index_out;
    logic [VALUE_W-1:0]   value_out;
    logic                 last_out;
  } out_item_t;

endpackage

@@ rtl/core/tmxn_in_if.sv @@
interface tmxn_in_if;
  logic                            valid;
  logic                            ready;
  logic [tmxn_pkg::REQ_TYPE_W-1:0] req_type;
  logic [tmxn_pkg::NODE_W-1:0]     src_node;
  logic [tmxn_pkg::REQN_W-1:0]     request_number;
  logic [tmxn_pkg::INDEX_W-1:0]    entry_index;
  logic [tmxn_pkg::VALUE_W-1:0]    entry_value;
  logic                            is_last;

  modport source (
    output valid, req_type, src_node, request_number, entry_index, entry_value, is_last,
    input  ready
  );
  modport sink (
    input  valid, req_type, src_node, request_number, entry_index, entry_value, is_last,
    output ready
  );
endinterface

@@ rtl/core/tmxn_out_if.sv @@
interface tmxn_out_if;
  logic                         valid;
  logic                         ready;
  logic [tmxn_pkg::KIND_W-1:0]  out_kind;
  logic [tmxn_pkg::DEST_W-1:0]  dest_node;
  logic [tmxn_pkg::SEQ_W-1:0]   seq_out;
  logic [tmxn_pkg::INDEX_W-1:0] index_out;
  logic [tmxn_pkg::VALUE_W-1:0] value_out;
  logic                         last_out;

  modport source (
    output valid, out_kind, dest_node, seq_out, index_out, value_out, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_kind, dest_node, seq_out, index_out, value_out, last_out,
    output ready
  );
endinterface

@@ rtl/core/token_mutual_exclusion_node_core.sv @@
// One node of token-passing mutual exclusion. Input items are local entry,
// remote request, token element and local exit; result items are request
// messages, token element messages and the entry grant, the final one of each
// run flagged by last_out. A small sequencer drives one shared compare unit
// and a pair of count tables with one read address, so the node takes one
// item at a time: an entry grant, a token element or an ignored item is done
// in the execute step; a remote request is then checked against the served
// count; a local entry without the token steps through every node number,
// self included, with one request per other node; an exit or a passing
// remote request searches up to NODES candidates, one candidate per cycle,
// and then sends the token vector. A stalled output holds the execute,
// request and send steps. After reset the node is number 1 and holds the
// token; writing node_number at byte address 0 reloads the token flag. No
// clearing pass after reset.
`include "token_mutual_exclusion_node_core_assert.svh"

module token_mutual_exclusion_node_core #(
  parameter int NODES      = tmxn_pkg::NODES_DEFAULT,
  parameter int COUNT_BITS = tmxn_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tmxn_in_if.sink                         in_i,
  tmxn_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tmxn_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tmxn_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tmxn_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(NODES);
  localparam int NUM_W = $clog2(NODES + 1);
  localparam int CMPW  = (NUM_W > tmxn_pkg::NODE_W) ? NUM_W : tmxn_pkg::NODE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOTE_CHK,
    S_SEARCH,
    S_SEND,
    S_REQ
  } state_e;

  state_e                       state_q;
  tmxn_pkg::req_type_e          kind_q;
  logic [tmxn_pkg::NODE_W-1:0]  src_q;
  logic [COUNT_BITS-1:0]        reqn_q;
  logic [tmxn_pkg::INDEX_W-1:0] idx_q;
  logic [COUNT_BITS-1:0]        val_q;
  logic                         last_q;

  logic [tmxn_pkg::NODE_W-1:0]  node_q;
  logic                         holding_q;
  logic                         inside_q;
  logic                         waiting_q;
  logic [COUNT_BITS-1:0]        own_q;
  logic [NUM_W-1:0]             cand_q;
  logic [IDX_W-1:0]             cnt_q;

  logic                         out_valid_q;
  tmxn_pkg::out_item_t          out_q;

  logic                         cfg_we;
  logic [tmxn_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         out_free;
  logic [CMPW-1:0]              node_w;
  logic [CMPW-1:0]              src_w;
  logic [CMPW-1:0]              cand_w;
  logic                         node_ok;
  logic                         src_ok;
  logic                         idx_ok;
  logic                         cand_is_self;
  logic                         req_last;
  logic                         send_last;
  logic [NUM_W-1:0]             cand_start;

  tmxn_pkg::cmp_op_e            cmp_op;
  logic                         cmp_gt;
  tmxn_pkg::tbl_we_t            tbl_we;
  logic [IDX_W-1:0]             tbl_waddr;
  logic [COUNT_BITS-1:0]        tbl_wdata;
  logic [IDX_W-1:0]             tbl_raddr;
  logic [COUNT_BITS-1:0]        hr_rd;
  logic [COUNT_BITS-1:0]        sc_rd;

  // configuration port
  assign reg_idx = paddr[tmxn_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready
                   && (reg_idx == tmxn_pkg::REG_NODE_NUMBER);
  assign prdata  = (reg_idx == tmxn_pkg::REG_NODE_NUMBER)
                   ? tmxn_pkg::APB_DATA_W'(node_q) : '0;

  // node number checks
  assign node_w       = CMPW'(node_q);
  assign src_w        = CMPW'(src_q);
  assign cand_w       = CMPW'(cand_q);
  assign node_ok      = (node_w != '0) && (node_w <= CMPW'(NODES));
  assign src_ok       = (src_w != '0) && (src_w <= CMPW'(NODES));
  assign idx_ok       = (CMPW'(idx_q) < CMPW'(NODES));
  assign cand_is_self = (cand_w == node_w);
  assign cand_start   = (node_w >= CMPW'(NODES)) ? NUM_W'(1) : NUM_W'(node_w + CMPW'(1));
  assign req_last     = (cand_w == CMPW'(NODES))
                        || ((cand_w == CMPW'(NODES - 1)) && (node_w == CMPW'(NODES)));
  assign send_last    = (cnt_q == IDX_W'(NODES - 1));

  assign out_free = !out_valid_q || out_o.ready;

  // table read address and compare operands follow the step
  always_comb begin
    case (state_q)
      S_EXEC: begin
        tbl_raddr = IDX_W'(src_w - CMPW'(1));
        cmp_op    = (kind_q == tmxn_pkg::REQ_ENTRY) ? tmxn_pkg::CMP_SAT
                                                    : tmxn_pkg::CMP_REQ_UPD;
      end
      S_REMOTE_CHK: begin
        tbl_raddr = IDX_W'(src_w - CMPW'(1));
        cmp_op    = tmxn_pkg::CMP_PENDING;
      end
      S_SEARCH: begin
        tbl_raddr = IDX_W'(cand_q - NUM_W'(1));
        cmp_op    = tmxn_pkg::CMP_PENDING;
      end
      S_SEND: begin
        tbl_raddr = cnt_q;
        cmp_op    = tmxn_pkg::CMP_PENDING;
      end
      default: begin
        tbl_raddr = '0;
        cmp_op    = tmxn_pkg::CMP_PENDING;
      end
    endcase
  end

  // table writes: new highest request, token element, own served count on exit
  always_comb begin
    tbl_we.hr_we = 1'b0;
    tbl_we.sc_we = 1'b0;
    tbl_waddr    = tbl_raddr;
    tbl_wdata    = reqn_q;
    if (state_q == S_EXEC && out_free) begin
      case (kind_q)
        tmxn_pkg::REQ_REMOTE: begin
          tbl_we.hr_we = src_ok && cmp_gt;
        end
        tmxn_pkg::REQ_TOKEN: begin
          tbl_we.sc_we = waiting_q && idx_ok;
          tbl_waddr    = IDX_W'(idx_q);
          tbl_wdata    = val_q;
        end
        tmxn_pkg::REQ_EXIT: begin
          tbl_we.sc_we = inside_q && node_ok;
          tbl_waddr    = IDX_W'(node_w - CMPW'(1));
          tbl_wdata    = own_q;
        end
        default: begin
          tbl_we.hr_we = 1'b0;
        end
      endcase
    end
  end

  tmxn_tables #(
    .NODES      (NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_tables (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (tbl_we),
    .waddr_i    (tbl_waddr),
    .wdata_i    (tbl_wdata),
    .raddr_i    (tbl_raddr),
    .hr_rdata_o (hr_rd),
    .sc_rdata_o (sc_rd)
  );

  tmxn_cmp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cmp (
    .op_i   (cmp_op),
    .reqn_i (reqn_q),
    .own_i  (own_q),
    .hr_i   (hr_rd),
    .sc_i   (sc_rd),
    .gt_o   (cmp_gt)
  );

  // sequencer, node state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= tmxn_pkg::REQ_ENTRY;
      src_q       <= '0;
      reqn_q      <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      last_q      <= 1'b0;
      node_q      <= tmxn_pkg::NODE_W'(1);
      holding_q   <= 1'b1;
      inside_q    <= 1'b0;
      waiting_q   <= 1'b0;
      own_q       <= '0;
      cand_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        node_q    <= pwdata[tmxn_pkg::NODE_W-1:0];
        holding_q <= (pwdata[tmxn_pkg::NODE_W-1:0] == tmxn_pkg::NODE_W'(1));
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            kind_q  <= tmxn_pkg::req_type_e'(in_i.req_type);
            src_q   <= in_i.src_node;
            reqn_q  <= COUNT_BITS'(in_i.request_number);
            idx_q   <= in_i.entry_index;
            val_q   <= COUNT_BITS'(in_i.entry_value);
            last_q  <= in_i.is_last;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_q <= S_IDLE;
            case (kind_q)
              tmxn_pkg::REQ_ENTRY: begin
                if (!inside_q && !waiting_q) begin
                  if (holding_q) begin
                    // immediate grant
                    inside_q           <= 1'b1;
                    out_valid_q        <= 1'b1;
                    out_q              <= '0;
                    out_q.out_kind     <= tmxn_pkg::KIND_GRANT;
                    out_q.dest_node    <= node_q;
                    out_q.last_out     <= 1'b1;
                  end else begin
                    // saturating count, then one request per other node
                    if (cmp_gt) begin
                      own_q <= own_q + COUNT_BITS'(1);
                    end
                    waiting_q <= 1'b1;
                    cand_q    <= NUM_W'(1);
                    state_q   <= S_REQ;
                  end
                end
              end
              tmxn_pkg::REQ_REMOTE: begin
                if (src_ok && holding_q && !inside_q) begin
                  state_q <= S_REMOTE_CHK;
                end
              end
              tmxn_pkg::REQ_TOKEN: begin
                if (waiting_q && last_q) begin
                  waiting_q       <= 1'b0;
                  holding_q       <= 1'b1;
                  inside_q        <= 1'b1;
                  out_valid_q     <= 1'b1;
                  out_q           <= '0;
                  out_q.out_kind  <= tmxn_pkg::KIND_GRANT;
                  out_q.dest_node <= node_q;
                  out_q.last_out  <= 1'b1;
                end
              end
              tmxn_pkg::REQ_EXIT: begin
                if (inside_q) begin
                  inside_q <= 1'b0;
                  cand_q   <= cand_start;
                  cnt_q    <= '0;
                  state_q  <= S_SEARCH;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_REMOTE_CHK: begin
          // the sender is pending after the update: look for the next holder
          if (cmp_gt) begin
            cand_q  <= cand_start;
            cnt_q   <= '0;
            state_q <= S_SEARCH;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SEARCH: begin
          // round robin, one candidate a cycle
          if (!cand_is_self && cmp_gt) begin
            cnt_q   <= '0;
            state_q <= S_SEND;
          end else if (send_last) begin
            state_q <= S_IDLE;
          end else begin
            cand_q <= (cand_w == CMPW'(NODES)) ? NUM_W'(1) : cand_q + NUM_W'(1);
            cnt_q  <= cnt_q + IDX_W'(1);
          end
        end
        S_SEND: begin
          // token vector, one element per item
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.out_kind  <= tmxn_pkg::KIND_TOKEN;
            out_q.dest_node <= tmxn_pkg::DEST_W'(cand_q);
            out_q.seq_out   <= '0;
            out_q.index_out <= tmxn_pkg::INDEX_W'(cnt_q);
            out_q.value_out <= tmxn_pkg::VALUE_W'(sc_rd);
            out_q.last_out  <= send_last;
            if (send_last) begin
              holding_q <= 1'b0;
              state_q   <= S_IDLE;
            end else begin
              cnt_q <= cnt_q + IDX_W'(1);
            end
          end
        end
        S_REQ: begin
          // request to every node but self, self as the top node ends the run
          if (cand_is_self) begin
            if (cand_w == CMPW'(NODES)) begin
              state_q <= S_IDLE;
            end else begin
              cand_q <= cand_q + NUM_W'(1);
            end
          end else if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.out_kind  <= tmxn_pkg::KIND_REQUEST;
            out_q.dest_node <= tmxn_pkg::DEST_W'(cand_q);
            out_q.seq_out   <= tmxn_pkg::SEQ_W'(own_q);
            out_q.index_out <= '0;
            out_q.value_out <= '0;
            out_q.last_out  <= req_last;
            if (cand_w == CMPW'(NODES)) begin
              state_q <= S_IDLE;
            end else begin
              cand_q <= cand_q + NUM_W'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // handshake and payload
  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.out_kind  = out_q.out_kind;
  assign out_o.dest_node = out_q.dest_node;
  assign out_o.seq_out   = out_q.seq_out;
  assign out_o.index_out = out_q.index_out;
  assign out_o.value_out = out_q.value_out;
  assign out_o.last_out  = out_q.last_out;

  // checks
  `TMXN_ASSERT_NEVER(a_inside_waiting, clk_i, rst_ni, inside_q && waiting_q, "inside while waiting for the token")
  `TMXN_ASSERT(a_grant_on_entry, clk_i, rst_ni, $rose(inside_q) |-> (out_valid_q && (out_q.out_kind == tmxn_pkg::KIND_GRANT)), "entry without a grant item")
  `TMXN_ASSERT(a_accept_busy, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> (state_q != S_IDLE), "accepted item not taken up")
  `TMXN_ASSERT(a_search_bound, clk_i, rst_ni, (state_q == S_SEARCH) |-> (32'(cnt_q) < NODES), "search ran past all nodes")
  `TMXN_ASSERT(a_send_bound, clk_i, rst_ni, (state_q == S_SEND) |-> (32'(cnt_q) < NODES), "token element index out of range")

endmodule

@@ rtl/core/tmxn_cmp.sv @@
module tmxn_cmp #(
  parameter int COUNT_BITS = tmxn_pkg::COUNT_BITS_DEFAULT
) (
  input  tmxn_pkg::cmp_op_e        op_i,
  input  logic [COUNT_BITS-1:0]    reqn_i,
  input  logic [COUNT_BITS-1:0]    own_i,
  input  logic [COUNT_BITS-1:0]    hr_i,
  input  logic [COUNT_BITS-1:0]    sc_i,
  output logic                     gt_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] a;
  logic [COUNT_BITS-1:0] b;

  // operand select
  always_comb begin
    case (op_i)
      tmxn_pkg::CMP_REQ_UPD: begin
        a = reqn_i;
        b = hr_i;
      end
      tmxn_pkg::CMP_PENDING: begin
        a = hr_i;
        b = sc_i;
      end
      tmxn_pkg::CMP_SAT: begin
        a = CNT_MAX;
        b = own_i;
      end
      default: begin
        a = hr_i;
        b = sc_i;
      end
    endcase
  end

  // the one magnitude compare
  assign gt_o = (a > b);

endmodule

@@ rtl/core/tmxn_tables.sv @@
module tmxn_tables #(
  parameter int NODES      = tmxn_pkg::NODES_DEFAULT,
  parameter int COUNT_BITS = tmxn_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tmxn_pkg::tbl_we_t           we_i,
  input  logic [$clog2(NODES)-1:0]    waddr_i,
  input  logic [COUNT_BITS-1:0]       wdata_i,
  input  logic [$clog2(NODES)-1:0]    raddr_i,
  output logic [COUNT_BITS-1:0]       hr_rdata_o,
  output logic [COUNT_BITS-1:0]       sc_rdata_o
);

  // highest request seen per node, served count per node
  logic [COUNT_BITS-1:0] hr_q [NODES];
  logic [COUNT_BITS-1:0] sc_q [NODES];

  // one write port per table, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NODES; k++) begin
        hr_q[k] <= '0;
        sc_q[k] <= '0;
      end
    end else begin
      if (we_i.hr_we) begin
        hr_q[waddr_i] <= wdata_i;
      end
      if (we_i.sc_we) begin
        sc_q[waddr_i] <= wdata_i;
      end
    end
  end

  // shared read address for both tables
  assign hr_rdata_o = hr_q[raddr_i];
  assign sc_rdata_o = sc_q[raddr_i];

endmodule

@@ tb/sv/tb_token_mutual_exclusion_node_core.sv @@
`timescale 1ns / 1ps

module tb_token_mutual_exclusion_node_core;
  import tmxn_pkg::*;

  localparam int NODES        = NODES_DEFAULT;
  localparam int DRAIN_CYCLES = 2 * NODES + 10;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 48;

  // one input item as the testbench sees it
  typedef struct packed {
    req_type_e          req_type;
    logic [NODE_W-1:0]  src_node;
    logic [REQN_W-1:0]  request_number;
    logic [INDEX_W-1:0] entry_index;
    logic [VALUE_W-1:0] entry_value;
    logic               is_last;
  } node_item_t;

  // shadow of the node: flags, counts and the messages still owed
  class token_node_ledger;
    out_item_t          due_msgs[$];
    int                 errors;
    int                 node_num;
    bit                 holding;
    bit                 in_section;
    bit                 waiting;
    logic [SEQ_W-1:0]   own_count;
    logic [VALUE_W-1:0] highest [NODES];
    logic [VALUE_W-1:0] served [NODES];

    function new();
      errors    = 0;
      own_count = '0;
      foreach (highest[i]) begin
        highest[i] = '0;
        served[i]  = '0;
      end
      set_node(1);
    endfunction

    // node number write reloads the token flag
    function void set_node(int n);
      node_num = n & 7;
      holding  = (node_num == 1);
    endfunction

    function void add_due(out_kind_e kind, int dest, logic [SEQ_W-1:0] seq, int idx,
                          logic [VALUE_W-1:0] val, bit last);
      out_item_t m;
      m.out_kind  = kind;
      m.dest_node = DEST_W'(dest);
      m.seq_out   = seq;
      m.index_out = INDEX_W'(idx);
      m.value_out = val;
      m.last_out  = last;
      due_msgs.push_back(m);
    endfunction

    // round-robin search from the next node, sends the whole served vector
    function void pass_token();
      int cand;
      cand = (node_num >= NODES) ? 1 : node_num + 1;
      for (int step = 0; step < NODES; step++) begin
        if (cand > NODES) cand = 1;
        if (cand != node_num && highest[cand-1] > served[cand-1]) begin
          for (int i = 0; i < NODES; i++) begin
            add_due(KIND_TOKEN, cand, '0, i, served[i], i == NODES - 1);
          end
          holding = 1'b0;
          return;
        end
        cand++;
      end
    endfunction

    // returns 1 when the item is not simply ignored by the node
    function bit take_item(node_item_t it);
      int last_dest;
      int src;
      src = it.src_node;
      case (it.req_type)
        REQ_ENTRY: begin
          if (in_section || waiting) return 1'b0;
          if (holding) begin
            in_section = 1'b1;
            add_due(KIND_GRANT, node_num, '0, 0, '0, 1'b1);
            return 1'b1;
          end
          if (own_count != '1) own_count++;
          waiting   = 1'b1;
          last_dest = (node_num == NODES) ? NODES - 1 : NODES;
          for (int i = 1; i <= NODES; i++) begin
            if (i != node_num) add_due(KIND_REQUEST, i, own_count, 0, '0, i == last_dest);
          end
          return 1'b1;
        end
        REQ_REMOTE: begin
          if (src == 0 || src > NODES) return 1'b0;
          if (it.request_number > highest[src-1]) highest[src-1] = it.request_number;
          if (holding && !in_section && highest[src-1] > served[src-1]) pass_token();
          return 1'b1;
        end
        REQ_TOKEN: begin
          if (!waiting) return 1'b0;
          if (it.entry_index < NODES) served[it.entry_index] = it.entry_value;
          if (it.is_last) begin
            waiting    = 1'b0;
            holding    = 1'b1;
            in_section = 1'b1;
            add_due(KIND_GRANT, node_num, '0, 0, '0, 1'b1);
          end
          return 1'b1;
        end
        default: begin
          if (!in_section) return 1'b0;
          if (node_num >= 1 && node_num <= NODES) served[node_num-1] = own_count;
          in_section = 1'b0;
          pass_token();
          return 1'b1;
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // compare one delivered message with the oldest one owed
    function void match_result(out_item_t got);
      out_item_t want;
      if (due_msgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d dest %0d",
                 $time, got.out_kind, got.dest_node);
        return;
      end
      want = due_msgs.pop_front();
      check_field("out_kind", want.out_kind, got.out_kind);
      check_field("dest_node", want.dest_node, got.dest_node);
      check_field("seq_out", want.seq_out, got.seq_out);
      check_field("index_out", want.index_out, got.index_out);
      check_field("value_out", want.value_out, got.value_out);
      check_field("last_out", want.last_out, got.last_out);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tmxn_in_if  in_if ();
  tmxn_out_if out_if ();

  token_node_ledger sb;
  bit               steady_flow;
  int               useful_items;
  int               quiet_cycles;
  int               phase_nodes [8] = '{3, 5, 0, 7, 2, 6, 4, 1};

  token_mutual_exclusion_node_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, none during the steady stretch
  always @(negedge clk) begin
    out_if.ready = steady_flow || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin : result_monitor
    out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.out_kind  = out_kind_e'(out_if.out_kind);
      got.dest_node = out_if.dest_node;
      got.seq_out   = out_if.seq_out;
      got.index_out = out_if.index_out;
      got.value_out = out_if.value_out;
      got.last_out  = out_if.last_out;
      sb.match_result(got);
    end
  end

  // stall watchdog: any handshake or register access resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function automatic node_item_t msg_item(req_type_e t, int src, int reqn, int idx, int val,
                                          bit last);
    node_item_t it;
    it.req_type       = t;
    it.src_node       = NODE_W'(src);
    it.request_number = REQN_W'(reqn);
    it.entry_index    = INDEX_W'(idx);
    it.entry_value    = VALUE_W'(val);
    it.is_last        = last;
    return it;
  endfunction

  // mostly small counts so requests and served values collide often
  function automatic int pick_count();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 12);
    return $urandom_range(0, 65535);
  endfunction

  function automatic node_item_t remote_item();
    int src;
    src = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7) : $urandom_range(1, NODES);
    return msg_item(REQ_REMOTE, src, pick_count(), $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 1));
  endfunction

  // drive one item at the falling edge, hold until the node takes it
  task automatic send_item(node_item_t it);
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 99) < 10) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_if.valid          = 1'b1;
    in_if.req_type       = it.req_type;
    in_if.src_node       = it.src_node;
    in_if.request_number = it.request_number;
    in_if.entry_index    = it.entry_index;
    in_if.entry_value    = it.entry_value;
    in_if.is_last        = it.is_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (sb.take_item(it)) useful_items++;
  endtask

  // arriving token: one element per node, sometimes a stray index or an early last
  task automatic send_token_vector();
    int  idx;
    bit  early;
    for (int i = 0; i < NODES; i++) begin
      idx   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : i;
      early = ($urandom_range(0, 19) == 0);
      send_item(msg_item(REQ_TOKEN, $urandom_range(0, 7), $urandom_range(0, 65535), idx,
                         pick_count(), early || i == NODES - 1));
    end
  endtask

  // protocol-shaped traffic driven by the shadow state, with some noise
  task automatic random_burst(int count);
    int stop_at;
    int roll;
    stop_at = useful_items + count;
    while (useful_items < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_item(msg_item(req_type_e'($urandom_range(0, 3)), $urandom_range(0, 7),
                           $urandom_range(0, 65535), $urandom_range(0, 7),
                           $urandom_range(0, 65535), $urandom_range(0, 1)));
      end else if (sb.waiting) begin
        if (roll < 25) send_item(remote_item());
        else send_token_vector();
      end else if (sb.in_section) begin
        if (roll < 60) send_item(remote_item());
        else send_item(msg_item(REQ_EXIT, 0, 0, 0, 0, 1'b0));
      end else if (roll < 65) begin
        send_item(msg_item(REQ_ENTRY, $urandom_range(0, 7), $urandom_range(0, 65535),
                           $urandom_range(0, 7), $urandom_range(0, 65535),
                           $urandom_range(0, 1)));
      end else begin
        send_item(remote_item());
      end
    end
  endtask

  // wait for every owed message, then let the sequencer settle
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.due_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node(int n);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'({REG_NODE_NUMBER, 2'b00});
    pwdata  = APB_DATA_W'(n);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_node(n);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    sb                   = new();
    steady_flow          = 1'b0;
    useful_items         = 0;
    quiet_cycles         = 0;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.req_type       = '0;
    in_if.src_node       = '0;
    in_if.request_number = '0;
    in_if.entry_index    = '0;
    in_if.entry_value    = '0;
    in_if.is_last        = 1'b0;
    out_if.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: node 1 after reset, starts with the token
    send_item(msg_item(REQ_EXIT, 0, 0, 0, 0, 1'b0));             // exit while outside
    send_item(msg_item(REQ_ENTRY, 0, 0, 0, 0, 1'b0));            // grant with token
    send_item(msg_item(REQ_ENTRY, 0, 0, 0, 0, 1'b0));            // entry while in section
    send_item(msg_item(REQ_REMOTE, 0, 16'hFFFF, 0, 0, 1'b0));    // sender zero
    send_item(msg_item(REQ_REMOTE, 7, 16'hFFFF, 7, 16'hFFFF, 1'b1)); // sender above range
    send_item(msg_item(REQ_REMOTE, 2, 5, 0, 0, 1'b0));           // pending while in section
    send_item(msg_item(REQ_REMOTE, 5, 16'hFFFF, 0, 0, 1'b0));
    send_item(msg_item(REQ_TOKEN, 7, 16'hFFFF, 7, 16'hFFFF, 1'b1)); // token not waited for
    send_item(msg_item(REQ_EXIT, 0, 0, 0, 0, 1'b0));             // exit passes to node 2
    send_item(msg_item(REQ_REMOTE, 3, 0, 0, 0, 1'b0));           // no token, nothing sent
    send_item(msg_item(REQ_ENTRY, 0, 0, 0, 0, 1'b0));            // requests to all others
    send_item(msg_item(REQ_ENTRY, 0, 0, 0, 0, 1'b0));            // entry while waiting
    send_item(msg_item(REQ_TOKEN, 0, 0, 0, 16'hFFFF, 1'b0));
    send_item(msg_item(REQ_TOKEN, 0, 0, 5, 16'hAAAA, 1'b0));     // index out of range
    send_item(msg_item(REQ_TOKEN, 0, 0, 1, 5, 1'b0));
    send_item(msg_item(REQ_TOKEN, 0, 0, 2, 0, 1'b0));
    send_item(msg_item(REQ_TOKEN, 0, 0, 3, 16'h5555, 1'b0));
    send_item(msg_item(REQ_TOKEN, 0, 0, 4, 16'hFFFF, 1'b0));
    send_item(msg_item(REQ_TOKEN, 0, 0, 6, 0, 1'b1));            // stray index still ends it
    send_item(msg_item(REQ_EXIT, 0, 0, 0, 0, 1'b0));             // nobody pending, token stays
    send_item(msg_item(REQ_REMOTE, 4, 3, 0, 0, 1'b0));           // already served
    send_item(msg_item(REQ_REMOTE, 3, 1, 0, 0, 1'b0));           // idle with token, passes
    send_item(msg_item(REQ_REMOTE, 1, 2, 0, 0, 1'b0));           // request naming itself
    drain();

    // random phases over a range of node numbers, one without idling
    foreach (phase_nodes[p]) begin
      write_node(phase_nodes[p]);
      steady_flow = (p == 4);
      random_burst(PHASE_ITEMS);
      drain();
    end
    steady_flow = 1'b0;

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
